>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the sorted priority deque.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define SPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/spd_pkg.sv
// Package for the sorted priority deque: codes, entry layout and the
// command/status structs between controller and datapath. No dependencies.
package spd_pkg;

	localparam int DEPTH_DEF = 16;

	// Command codes carried on the cmd port.
	typedef enum logic [1:0] {
		CMD_INSERT    = 2'd0,
		CMD_POP_FRONT = 2'd1,
		CMD_POP_BACK  = 2'd2,
		CMD_SEARCH    = 2'd3
	} cmd_t;

	// Status codes returned with every result.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} sts_t;

	// One stored job.
	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  jtype;
		logic [7:0]  prio;
		logic [15:0] jtime;
	} entry_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_INSERT,
		OP_REJECT,
		OP_EMPTY,
		OP_POP_FRONT,
		OP_SCAN_INIT,
		OP_ROTATE,
		OP_SEARCH_END
	} op_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN
	} state_t;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic empty;
		logic full;
		logic rem_zero;
	} stat_t;

endpackage

>>> src/spd_ctrl.sv
// Controller of the sorted priority deque: sequences each command as
// datapath operations. Depends on spd_pkg.
module spd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  spd_pkg::stat_t stat,
	output spd_pkg::ctrl_t ctrl,
	output logic           busy
);

	spd_pkg::state_t state_q;
	spd_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath operation.
	always_comb begin
		state_d = state_q;
		ctrl.op = spd_pkg::OP_NONE;
		busy    = 1'b1;
		case (state_q)
			spd_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.op = spd_pkg::OP_LOAD;
					state_d = spd_pkg::S_EXEC;
				end
			end
			spd_pkg::S_EXEC: begin
				state_d = spd_pkg::S_IDLE;
				case (stat.cmd)
					spd_pkg::CMD_INSERT: begin
						ctrl.op = stat.full ? spd_pkg::OP_REJECT : spd_pkg::OP_INSERT;
					end
					spd_pkg::CMD_POP_FRONT: begin
						ctrl.op = stat.empty ? spd_pkg::OP_EMPTY : spd_pkg::OP_POP_FRONT;
					end
					spd_pkg::CMD_POP_BACK: begin
						if (stat.empty) begin
							ctrl.op = spd_pkg::OP_EMPTY;
						end else begin
							ctrl.op = spd_pkg::OP_SCAN_INIT;
							state_d = spd_pkg::S_SCAN;
						end
					end
					default: begin
						ctrl.op = spd_pkg::OP_SCAN_INIT;
						state_d = spd_pkg::S_SCAN;
					end
				endcase
			end
			spd_pkg::S_SCAN: begin
				if (stat.rem_zero) begin
					state_d = spd_pkg::S_IDLE;
					if (stat.cmd == spd_pkg::CMD_POP_BACK) begin
						ctrl.op = spd_pkg::OP_POP_FRONT;
					end else begin
						ctrl.op = spd_pkg::OP_SEARCH_END;
					end
				end else begin
					ctrl.op = spd_pkg::OP_ROTATE;
				end
			end
			default: begin
				state_d = spd_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> src/spd_datapath.sv
// Datapath of the sorted priority deque: the sorted row of entry cells,
// the fill count, the scan counter and the result registers.
// Depends on spd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spd_datapath #(
	parameter int DEPTH = spd_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  spd_pkg::ctrl_t ctrl,
	output spd_pkg::stat_t stat,
	input  logic [1:0]     cmd,
	input  logic [15:0]    job_id,
	input  logic [7:0]     job_type,
	input  logic [7:0]     job_prio,
	input  logic [15:0]    job_time,
	output logic           done,
	output logic [1:0]     status,
	output logic [15:0]    out_id,
	output logic [7:0]     out_type,
	output logic [7:0]     out_priority,
	output logic [15:0]    out_time,
	output logic [4:0]     occupancy
);

	localparam int CW = $clog2(DEPTH + 1);

	spd_pkg::entry_t cells_q [DEPTH];
	spd_pkg::entry_t cells_d [DEPTH];
	logic [DEPTH-1:0] gt;

	spd_pkg::cmd_t   cmd_q;
	spd_pkg::entry_t job_q;
	spd_pkg::entry_t hit_q;
	logic            found_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_d;
	logic [CW-1:0]   rem_q;
	logic [CW+4:0]   occ_ext;

	logic            done_q;
	spd_pkg::sts_t   status_q;
	spd_pkg::entry_t res_q;
	logic [4:0]      occupancy_q;

	// Status towards the controller.
	assign stat.cmd      = cmd_q;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CW'(DEPTH));
	assign stat.rem_zero = (rem_q == '0);

	// Each cell picks its next value from its neighbours. An insert lands
	// at the first cell whose priority is larger or which is unused; the
	// cells behind it move back by one. A rotation moves the used part of
	// the row forward by one and wraps the front cell to the tail.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		localparam logic [CW-1:0] NXT = CW'(i + 1);
		spd_pkg::entry_t prev_e;
		spd_pkg::entry_t next_e;
		logic            gt_prev;

		assign gt[i] = !((IDX < count_q) && (cells_q[i].prio <= job_q.prio));

		if (i == 0) begin : g_first
			assign prev_e  = job_q;
			assign gt_prev = 1'b1;
		end else begin : g_inner
			assign prev_e  = cells_q[i-1];
			assign gt_prev = gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_e = cells_q[i];
		end else begin : g_body
			assign next_e = cells_q[i+1];
		end

		always_comb begin
			cells_d[i] = cells_q[i];
			case (ctrl.op)
				spd_pkg::OP_INSERT: begin
					if (gt[i]) begin
						cells_d[i] = gt_prev ? prev_e : job_q;
					end
				end
				spd_pkg::OP_POP_FRONT: begin
					cells_d[i] = next_e;
				end
				spd_pkg::OP_ROTATE: begin
					if (NXT < count_q) begin
						cells_d[i] = next_e;
					end else if (NXT == count_q) begin
						cells_d[i] = cells_q[0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Cell row storage.
	always_ff @(posedge clk) begin
		for (int k = 0; k < DEPTH; k++) begin
			cells_q[k] <= cells_d[k];
		end
	end

	// Fill count after the current operation.
	always_comb begin
		count_d = count_q;
		case (ctrl.op)
			spd_pkg::OP_INSERT:    count_d = count_q + 1'b1;
			spd_pkg::OP_POP_FRONT: count_d = count_q - 1'b1;
			default:               count_d = count_q;
		endcase
	end

	assign occ_ext = {5'd0, count_d};

	// Control registers: fill count, scan counter, match flag, strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= 1'b0;
			case (ctrl.op)
				spd_pkg::OP_SCAN_INIT: begin
					rem_q   <= (cmd_q == spd_pkg::CMD_POP_BACK) ? count_q - 1'b1 : count_q;
					found_q <= 1'b0;
				end
				spd_pkg::OP_ROTATE: begin
					rem_q <= rem_q - 1'b1;
					if ((cmd_q == spd_pkg::CMD_SEARCH) && !found_q &&
					    (cells_q[0].id == job_q.id)) begin
						found_q <= 1'b1;
					end
				end
				spd_pkg::OP_INSERT, spd_pkg::OP_REJECT, spd_pkg::OP_EMPTY,
				spd_pkg::OP_POP_FRONT, spd_pkg::OP_SEARCH_END: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Command latch, search hit and result payload.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			spd_pkg::OP_LOAD: begin
				cmd_q       <= spd_pkg::cmd_t'(cmd);
				job_q.id    <= job_id;
				job_q.jtype <= job_type;
				job_q.prio  <= job_prio;
				job_q.jtime <= job_time;
			end
			spd_pkg::OP_ROTATE: begin
				if ((cmd_q == spd_pkg::CMD_SEARCH) && !found_q &&
				    (cells_q[0].id == job_q.id)) begin
					hit_q <= cells_q[0];
				end
			end
			spd_pkg::OP_INSERT: begin
				status_q    <= spd_pkg::ST_OK;
				res_q       <= '0;
				occupancy_q <= occ_ext[4:0];
			end
			spd_pkg::OP_REJECT: begin
				status_q    <= spd_pkg::ST_FULL;
				res_q       <= '0;
				occupancy_q <= occ_ext[4:0];
			end
			spd_pkg::OP_EMPTY: begin
				status_q    <= spd_pkg::ST_EMPTY;
				res_q       <= '0;
				occupancy_q <= occ_ext[4:0];
			end
			spd_pkg::OP_POP_FRONT: begin
				status_q    <= spd_pkg::ST_OK;
				res_q       <= cells_q[0];
				occupancy_q <= occ_ext[4:0];
			end
			spd_pkg::OP_SEARCH_END: begin
				status_q    <= found_q ? spd_pkg::ST_OK : spd_pkg::ST_NOT_FOUND;
				res_q       <= found_q ? hit_q : '0;
				occupancy_q <= occ_ext[4:0];
			end
			default: begin
			end
		endcase
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_id       = res_q.id;
	assign out_type     = res_q.jtype;
	assign out_priority = res_q.prio;
	assign out_time     = res_q.jtime;
	assign occupancy    = occupancy_q;

	// Checks on the fill count, the scan counter and the result strobe.
	`SPD_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "fill count beyond depth")
	`SPD_ASSERT(a_no_insert_full, (ctrl.op == spd_pkg::OP_INSERT) |-> !stat.full, "insert when full")
	`SPD_ASSERT(a_rotate_rem, (ctrl.op == spd_pkg::OP_ROTATE) |-> !stat.rem_zero, "rotate past end")
	`SPD_ASSERT_NEXT(a_insert_count, ctrl.op == spd_pkg::OP_INSERT, count_q == CW'($past(count_q) + 1'b1), "insert count")
	`SPD_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe longer than one cycle")

endmodule

>>> src/sorted_priority_deque.sv
// Top level of the sorted priority deque: controller plus datapath.
// Depends on spd_pkg, spd_ctrl and spd_datapath.
//
//  channel   handshake          payload
//  command   start, busy        cmd, job_id, job_type, job_prio, job_time
//  result    done (one cycle)   status, out_id, out_type, out_priority, out_time, occupancy
//
// A command is taken when start is high and busy is low; busy stays high
// until the result strobe is raised, and a new command may be taken in
// that strobe cycle. Insert and pop front need no scan; pop back and
// search rotate the cell row one place per cycle. Reset clears the fill
// count; no clearing pass.
module sorted_priority_deque #(
	parameter int DEPTH = spd_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [15:0] job_id,
	input  logic [7:0]  job_type,
	input  logic [7:0]  job_prio,
	input  logic [15:0] job_time,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] out_id,
	output logic [7:0]  out_type,
	output logic [7:0]  out_priority,
	output logic [15:0] out_time,
	output logic [4:0]  occupancy
);

	spd_pkg::ctrl_t ctrl;
	spd_pkg::stat_t stat;

	// Command sequencer.
	spd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Cell row and result registers.
	spd_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.cmd          (cmd),
		.job_id       (job_id),
		.job_type     (job_type),
		.job_prio     (job_prio),
		.job_time     (job_time),
		.done         (done),
		.status       (status),
		.out_id       (out_id),
		.out_type     (out_type),
		.out_priority (out_priority),
		.out_time     (out_time),
		.occupancy    (occupancy)
	);

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the sorted priority deque: directed and random commands,
// with each result checked against a priority-ordered job store kept alongside.
// Depends on spd_pkg and the sorted_priority_deque RTL.
module testbench;

	localparam int DEPTH = spd_pkg::DEPTH_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 3 * DEPTH;

	// One command waiting to be offered, with the idle odds of its phase.
	typedef struct {
		spd_pkg::cmd_t   op;
		spd_pkg::entry_t job;
		int unsigned     gap_pct;
	} command_t;

	// One result as the deque should report it.
	typedef struct {
		spd_pkg::sts_t   status;
		spd_pkg::entry_t job;
		logic [4:0]      occupancy;
	} result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	spd_pkg::cmd_t cmd = spd_pkg::CMD_INSERT;
	logic [15:0]   job_id = '0;
	logic [7:0]    job_type = '0;
	logic [7:0]    job_prio = '0;
	logic [15:0]   job_time = '0;
	logic          busy;
	logic          done;
	logic [1:0]    status;
	logic [15:0]   out_id;
	logic [7:0]    out_type;
	logic [7:0]    out_priority;
	logic [15:0]   out_time;
	logic [4:0]    occupancy;

	command_t        pending_commands[$];
	result_t         expected_results[$];
	spd_pkg::entry_t job_row[DEPTH];
	int              job_count = 0;
	int              mismatch_count = 0;
	int              quiet_cycles = 0;

	sorted_priority_deque #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.job_id(job_id),
		.job_type(job_type),
		.job_prio(job_prio),
		.job_time(job_time),
		.done(done),
		.status(status),
		.out_id(out_id),
		.out_type(out_type),
		.out_priority(out_priority),
		.out_time(out_time),
		.occupancy(occupancy)
	);

	// Clock with a period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Prints one line per mismatch and keeps the tally.
	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatch_count++;
		$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
	endtask

	// Applies one command to the job store and returns the result it should give.
	function automatic result_t apply_to_store(input spd_pkg::cmd_t op,
			input spd_pkg::entry_t job);
		result_t res;
		int      pos;
		int      i;
		res.status = spd_pkg::ST_OK;
		res.job = '0;
		case (op)
		spd_pkg::CMD_INSERT: begin
			if (job_count >= DEPTH) begin
				res.status = spd_pkg::ST_FULL;
			end else begin
				// Equal priorities keep arrival order: go past every entry not larger.
				pos = 0;
				while (pos < job_count && job_row[pos].prio <= job.prio)
					pos++;
				for (i = job_count; i > pos; i--)
					job_row[i] = job_row[i - 1];
				job_row[pos] = job;
				job_count++;
			end
		end
		spd_pkg::CMD_POP_FRONT: begin
			if (job_count == 0) begin
				res.status = spd_pkg::ST_EMPTY;
			end else begin
				res.job = job_row[0];
				for (i = 0; i + 1 < job_count; i++)
					job_row[i] = job_row[i + 1];
				job_count--;
			end
		end
		spd_pkg::CMD_POP_BACK: begin
			if (job_count == 0) begin
				res.status = spd_pkg::ST_EMPTY;
			end else begin
				res.job = job_row[job_count - 1];
				job_count--;
			end
		end
		default: begin
			// Search takes the first match counted from the front.
			res.status = spd_pkg::ST_NOT_FOUND;
			for (i = job_count - 1; i >= 0; i--) begin
				if (job_row[i].id == job.id) begin
					res.status = spd_pkg::ST_OK;
					res.job = job_row[i];
				end
			end
		end
		endcase
		res.occupancy = 5'(job_count);
		return res;
	endfunction

	function automatic command_t random_command(input int unsigned insert_pct,
			input int unsigned gap_pct);
		command_t c;
		if ($urandom_range(99) < insert_pct)
			c.op = spd_pkg::CMD_INSERT;
		else
			c.op = spd_pkg::cmd_t'($urandom_range(3, 1));
		// A small identifier pool makes searches hit and gives repeated identifiers.
		c.job.id = ($urandom_range(99) < 70) ? 16'($urandom_range(15)) : 16'($urandom);
		c.job.jtype = 8'($urandom);
		// Low priorities from a narrow range give plenty of ties.
		c.job.prio = ($urandom_range(99) < 60) ? 8'($urandom_range(3)) : 8'($urandom);
		c.job.jtime = 16'($urandom);
		c.gap_pct = gap_pct;
		return c;
	endfunction

	task automatic queue_command(input spd_pkg::cmd_t op, input logic [15:0] id,
			input logic [7:0] jtype, input logic [7:0] prio, input logic [15:0] jtime);
		command_t c;
		c.op = op;
		c.job = '{id: id, jtype: jtype, prio: prio, jtime: jtime};
		c.gap_pct = 0;
		pending_commands.push_back(c);
	endtask

	// Command driver: holds a command until its transfer, then offers the next one or idles.
	always @(posedge clk) begin : drive_commands
		command_t next_cmd;
		if (arst_n) begin
			if (start && !busy)
				expected_results.push_back(apply_to_store(cmd, '{id: job_id,
						jtype: job_type, prio: job_prio, jtime: job_time}));
			if (!(start && busy)) begin
				if (pending_commands.size() != 0
						&& $urandom_range(99) >= pending_commands[0].gap_pct) begin
					next_cmd = pending_commands.pop_front();
					start <= 1'b1;
					cmd <= next_cmd.op;
					job_id <= next_cmd.job.id;
					job_type <= next_cmd.job.jtype;
					job_prio <= next_cmd.job.prio;
					job_time <= next_cmd.job.jtime;
				end else begin
					// While idle the fields carry noise that must be ignored.
					start <= 1'b0;
					cmd <= spd_pkg::cmd_t'($urandom_range(3));
					job_id <= 16'($urandom);
					job_type <= 8'($urandom);
					job_prio <= 8'($urandom);
					job_time <= 16'($urandom);
				end
			end
		end
	end

	// Result monitor: every strobed result is checked against the oldest expectation.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", 16'(status), 16'(0));
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 16'(status), 16'(want.status));
				if (out_id !== want.job.id)
					report_mismatch("out_id", out_id, want.job.id);
				if (out_type !== want.job.jtype)
					report_mismatch("out_type", 16'(out_type), 16'(want.job.jtype));
				if (out_priority !== want.job.prio)
					report_mismatch("out_priority", 16'(out_priority), 16'(want.job.prio));
				if (out_time !== want.job.jtime)
					report_mismatch("out_time", out_time, want.job.jtime);
				if (occupancy !== want.occupancy)
					report_mismatch("occupancy", 16'(occupancy), 16'(want.occupancy));
			end
		end
	end

	// Watchdog: ends the run when no transfer or result has been seen for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		int unsigned phase_gap[4];
		int unsigned insert_pct;
		int          i;
		int          n;
		phase_gap = '{0, 88, 0, 36};

		// Directed part: empty deque, field extremes, ties, filling up and a rejected insert.
		queue_command(spd_pkg::CMD_POP_FRONT, 16'h1234, 8'h00, 8'h00, 16'h0000);
		queue_command(spd_pkg::CMD_POP_BACK, 16'h4321, 8'hFF, 8'hFF, 16'hFFFF);
		queue_command(spd_pkg::CMD_SEARCH, 16'hFFFF, 8'h00, 8'h00, 16'h0000);
		queue_command(spd_pkg::CMD_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
		queue_command(spd_pkg::CMD_INSERT, 16'h0000, 8'h00, 8'h00, 16'h0000);
		queue_command(spd_pkg::CMD_INSERT, 16'h0001, 8'h5A, 8'h00, 16'hA5A5);
		queue_command(spd_pkg::CMD_INSERT, 16'h0002, 8'hA5, 8'hFF, 16'h5A5A);
		queue_command(spd_pkg::CMD_SEARCH, 16'h0000, 8'hFF, 8'hFF, 16'hFFFF);
		queue_command(spd_pkg::CMD_SEARCH, 16'h1234, 8'h00, 8'h00, 16'h0000);
		for (i = 0; i < DEPTH - 4; i++)
			queue_command(spd_pkg::CMD_INSERT, 16'(16'h0100 + i), 8'(i), 8'(i * 37),
					16'(i * 4099));
		queue_command(spd_pkg::CMD_INSERT, 16'hBEEF, 8'h11, 8'h01, 16'h2222);
		queue_command(spd_pkg::CMD_SEARCH, 16'hFFFF, 8'h00, 8'h00, 16'h0000);
		queue_command(spd_pkg::CMD_POP_FRONT, 16'h0000, 8'h00, 8'h00, 16'h0000);
		queue_command(spd_pkg::CMD_POP_BACK, 16'h0000, 8'h00, 8'h00, 16'h0000);

		// Random part: four idling phases, each in bursts that fill, drain or hover.
		for (i = 0; i < 4; i++) begin
			for (n = 0; n < 190; n++) begin
				if (n % 20 == 0) begin
					case ($urandom_range(2))
					0: insert_pct = 75;
					1: insert_pct = 20;
					default: insert_pct = 45;
					endcase
				end
				pending_commands.push_back(random_command(insert_pct, phase_gap[i]));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_commands.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never delivered", 16'(expected_results.size()), 16'(0));
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
